FILE: src/agcm_pkg.sv
// ============================================================================
// AES-256-GCM decrypt package
// Shared types, item structs, S-box and GF(2^128) helpers.
// ============================================================================
package agcm_pkg;

    localparam int CountBitsDefault = 36;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_TAG   = 2'd2;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_IVUP  = 3'd4;
    localparam logic [2:0] REG_IVLO  = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cipher_byte;
        logic [63:0] tag_upper;
        logic [63:0] tag_lower;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] plain_byte;
        logic       tag_match;
    } t_out_item;

    // Request to the AES core and its round-key memory.
    typedef struct packed {
        logic         go;
        logic [127:0] block;
    } t_aes_req;

    typedef struct packed {
        logic         done;
        logic [127:0] block;
    } t_aes_rsp;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte 0 of the block is bits 127:120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i+4*c] = b[i + 4*((c+i) % 4)];
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
        return r;
    endfunction

    // One step of the shift-and-add product: v times x^8 in GCM order.
    function automatic logic [127:0] gf_shift8(input logic [127:0] v);
        logic [127:0] r;
        r = v;
        for (int k = 0; k < 8; k++) r = {1'b0, r[127:1]} ^ (r[0] ? {8'he1, 120'd0} : 128'd0);
        return r;
    endfunction

    // Accumulate eight bits of x (MSB first) against v, v advancing per bit.
    function automatic logic [127:0] gf_digit(input logic [7:0] d, input logic [127:0] v);
        logic [127:0] acc, w;
        acc = '0;
        w   = v;
        for (int k = 0; k < 8; k++) begin
            if (d[7-k]) acc = acc ^ w;
            w = {1'b0, w[127:1]} ^ (w[0] ? {8'he1, 120'd0} : 128'd0);
        end
        return acc;
    endfunction

endpackage

FILE: src/agcm_aes.sv
// ============================================================================
// AES-256 round engine
// Key expansion and block encryption, one round per cycle, round keys held
// in a 15-entry synchronous memory.
// ============================================================================
module agcm_aes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_expand,
    input  logic [255:0]      i_key,
    input  agcm_pkg::t_aes_req i_req,
    output logic              o_busy,
    output agcm_pkg::t_aes_rsp o_rsp
);
    import agcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXP  = 4'b0010,
        S_ENC  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    logic [127:0] r_rk_mem [15];
    logic [127:0] r_rk_q;
    logic [3:0]   r_rd_addr;

    t_state       r_state, n_state;
    logic [3:0]   r_idx, n_idx;
    logic [255:0] r_kw, n_kw;
    logic [7:0]   r_rcon, n_rcon;
    logic [127:0] r_blk, n_blk;
    logic         r_first, n_first;

    logic         wr_en;
    logic [3:0]   wr_addr;
    logic [127:0] wr_data;
    logic [3:0]   rd_addr;
    logic [127:0] kg_a, kg_b;

    // Next eight words of the schedule from the previous eight.
    always_comb begin
        logic [31:0] w [8];
        logic [31:0] t;
        for (int i = 0; i < 8; i++) w[i] = r_kw[255-32*i -: 32];
        t = sub_word({r_kw[23:0], r_kw[31:24]}) ^ {r_rcon, 24'd0};
        w[0] = w[0] ^ t;
        for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i-1];
        w[4] = w[4] ^ sub_word(w[3]);
        for (int i = 5; i < 8; i++) w[i] = w[i] ^ w[i-1];
        kg_a = {w[0], w[1], w[2], w[3]};
        kg_b = {w[4], w[5], w[6], w[7]};
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_kw    = r_kw;
        n_rcon  = r_rcon;
        n_blk   = r_blk;
        n_first = r_first;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_kw[255:128];
        rd_addr = 4'd0;
        case (r_state)
            S_IDLE: begin
                if (i_expand) begin
                    n_state = S_EXP;
                    n_kw    = i_key;
                    n_idx   = 4'd0;
                    n_rcon  = 8'h01;
                    n_first = 1'b1;
                end else if (i_req.go) begin
                    n_state = S_ENC;
                    n_blk   = i_req.block;
                    n_idx   = 4'd1;
                    rd_addr = 4'd0;
                    n_first = 1'b1;
                end
            end
            // Two round keys per schedule step: the upper half then the lower.
            S_EXP: begin
                wr_en = 1'b1;
                if (r_first) begin
                    wr_data = r_kw[255:128];
                    n_first = 1'b0;
                end else begin
                    wr_data = r_kw[127:0];
                    n_first = 1'b1;
                    n_kw    = {kg_a, kg_b};
                    n_rcon  = xt(r_rcon);
                end
                if (r_idx == 4'd14) begin
                    n_state = S_IDLE;
                end
                n_idx = r_idx + 4'd1;
            end
            S_ENC: begin
                if (r_first) begin
                    n_blk   = r_blk ^ r_rk_q;
                    n_first = 1'b0;
                    rd_addr = r_idx;
                end else begin
                    n_blk = aes_round(r_blk, r_idx == 4'd14) ^ r_rk_q;
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd14) begin
                        n_state = S_DONE;
                        rd_addr = r_idx;
                    end else begin
                        rd_addr = r_idx + 4'd1;
                    end
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The key for the next round is read in the cycle before its use.
    // The first cycle only adds key 0 and the round counter holds for it.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_rk_mem[wr_addr] <= wr_data;
        r_rk_q <= r_rk_mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 4'd0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_first <= n_first;
        end
        r_kw   <= n_kw;
        r_rcon <= n_rcon;
        r_blk  <= n_blk;
    end

    assign o_busy      = (r_state != S_IDLE) || i_expand || i_req.go;
    assign o_rsp.done  = (r_state == S_DONE);
    assign o_rsp.block = r_blk;

    a_done_after_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> $past(r_state) == S_ENC) else $error("done without round");
    a_rd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ENC && !r_first |-> r_rd_addr == r_idx)
        else $error("key address skew");
    a_exp_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == S_EXP) else $error("stray key write");
endmodule

FILE: src/agcm_ghash.sv
// ============================================================================
// GHASH digit-serial multiplier
// Multiplies (acc xor block) by H eight bits a cycle.
// ============================================================================
module agcm_ghash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [127:0] i_x,
    input  logic [127:0] i_h,
    output logic         o_done,
    output logic [127:0] o_z
);
    import agcm_pkg::*;

    logic         r_run;
    logic [4:0]   r_cnt;
    logic [127:0] r_x, r_v, r_acc;
    logic         r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go && !r_run) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_go && !r_run) begin
            r_x   <= i_x;
            r_v   <= i_h;
            r_acc <= '0;
        end else if (r_run) begin
            r_x   <= {r_x[119:0], 8'd0};
            r_v   <= gf_shift8(r_v);
            r_acc <= r_acc ^ gf_digit(r_x[127:120], r_v);
        end
    end

    assign o_done = r_done;
    assign o_z    = r_acc;

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_cnt) == 5'd15) else $error("short product");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run && !$past(r_run) |-> r_cnt == 5'd0) else $error("bad start");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("double done");
endmodule

FILE: src/aes256_gcm_stream_decrypt.sv
// ============================================================================
// AES-256-GCM stream decrypt
// Byte-wide GCM decryption with empty additional data and tag check.
// ============================================================================
//  channel | direction | handshake
//  input   | in        | i_in_valid / o_in_stall, payload i_in
//  output  | out       | o_out_valid / i_out_stall, payload o_out
//  config  | in        | APB write at psel & penable & pwrite
//
// A start item expands the key into the round-key memory, runs the AES of the
// zero block and loads the output register. A byte item first runs the AES for
// a new keystream block when one is due, and after its byte folds the 16-byte
// GHASH block when that is full. A check item folds a partial block first if
// there is one, then the length block, and then runs the AES of counter 1.
// One item is worked on at a time and input stalls until its result has left.
// Reset is synchronous and clears the control state; the round-key memory is
// not cleared. A stalled result holds in the output register.
module aes256_gcm_stream_decrypt #(
    parameter int COUNT_BITS = agcm_pkg::CountBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  agcm_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output agcm_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import agcm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_EXP   = 8'b00000010,
        S_AES   = 8'b00000100,
        S_BYTE  = 8'b00001000,
        S_HASH  = 8'b00010000,
        S_LEN   = 8'b00100000,
        S_TAG   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    logic [63:0] r_key [4];
    logic [63:0] r_iv_up;
    logic [31:0] r_iv_lo;

    t_state          r_state;
    t_in_item        r_item;
    logic [127:0]    r_h, r_ks, r_acc, r_part, r_tacc;
    logic [95:0]     r_nonce;
    logic [31:0]     r_ctr;
    logic [4:0]      r_used;
    logic [3:0]      r_fill;
    logic [COUNT_BITS-1:0] r_count;
    logic            r_out_valid;
    t_out_item       r_out;
    logic            r_wait;

    t_aes_req aes_req;
    t_aes_rsp aes_rsp;
    logic     aes_busy, aes_expand;
    logic     gh_go, gh_done;
    logic [127:0] gh_x, gh_z;
    logic [2:0]   reg_idx;
    logic         acc_in;
    logic [63:0]  len_bits;
    logic [127:0] padded;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    always_comb begin
        case (reg_idx)
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            REG_IVUP: prdata = r_iv_up;
            REG_IVLO: prdata = {32'd0, r_iv_lo};
            default:  prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '{default: 64'd0};
            r_iv_up <= 64'd0;
            r_iv_lo <= 32'd0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_KEY0: r_key[0] <= pwdata;
                REG_KEY1: r_key[1] <= pwdata;
                REG_KEY2: r_key[2] <= pwdata;
                REG_KEY3: r_key[3] <= pwdata;
                REG_IVUP: r_iv_up  <= pwdata;
                REG_IVLO: r_iv_lo  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    assign acc_in     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign aes_expand = (r_state == S_EXP) && !r_wait;
    assign len_bits   = 64'({r_count, 3'b000});

    always_comb begin
        padded = r_part;
        for (int i = 0; i < 16; i++)
            if (4'(i) >= r_fill) padded[127-8*i -: 8] = 8'd0;
    end

    always_comb begin
        aes_req.go    = 1'b0;
        aes_req.block = '0;
        gh_go = 1'b0;
        gh_x  = r_acc ^ r_part;
        case (r_state)
            S_AES: begin
                aes_req.go = !r_wait;
                if (r_item.mode == MODE_START) aes_req.block = '0;
                else if (r_item.mode == MODE_CHECK) aes_req.block = {r_nonce, 32'd1};
                else aes_req.block = {r_nonce, r_ctr};
            end
            S_HASH: begin
                gh_go = !r_wait;
                gh_x  = (r_item.mode == MODE_CHECK) ? r_acc ^ padded : r_acc ^ r_part;
            end
            S_LEN: begin
                gh_go = !r_wait;
                gh_x  = r_tacc ^ {64'd0, len_bits};
            end
            default: ;
        endcase
    end

    agcm_aes u_aes (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_expand(aes_expand),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_req(aes_req), .o_busy(aes_busy), .o_rsp(aes_rsp)
    );

    agcm_ghash u_ghash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(gh_go), .i_x(gh_x),
        .i_h(r_h), .o_done(gh_done), .o_z(gh_z)
    );

    always_ff @(posedge i_clk) begin
        logic [7:0] pb;
        pb = 8'd0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_h     <= '0;
            r_nonce <= '0;
            r_ctr   <= '0;
            r_ks    <= '0;
            r_used  <= 5'd16;
            r_acc   <= '0;
            r_part  <= '0;
            r_fill  <= 4'd0;
            r_count <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_item <= i_in;
                        r_wait <= 1'b0;
                        case (i_in.mode)
                            MODE_START: begin
                                r_state <= S_EXP;
                                r_nonce <= {r_iv_up, r_iv_lo};
                                r_ctr   <= 32'd2;
                                r_ks    <= '0;
                                r_used  <= 5'd16;
                                r_acc   <= '0;
                                r_part  <= '0;
                                r_fill  <= 4'd0;
                                r_count <= '0;
                            end
                            MODE_BYTE: r_state <= (r_used[4]) ? S_AES : S_BYTE;
                            MODE_CHECK: begin
                                r_tacc  <= r_acc;
                                r_state <= (r_fill != 4'd0) ? S_HASH : S_LEN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EXP: begin
                    if (r_wait && !aes_busy) begin
                        r_state <= S_AES;
                        r_wait  <= 1'b0;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_AES: begin
                    if (aes_rsp.done) begin
                        r_wait <= 1'b0;
                        case (r_item.mode)
                            MODE_START: begin
                                r_h   <= aes_rsp.block;
                                r_out <= '{KIND_START, 8'd0, 1'b0};
                                r_state <= S_OUT;
                            end
                            MODE_CHECK: begin
                                r_out <= '{KIND_TAG, 8'd0,
                                    (aes_rsp.block ^ r_tacc) ==
                                    {r_item.tag_upper, r_item.tag_lower}};
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_ks    <= aes_rsp.block;
                                r_ctr   <= r_ctr + 32'd1;
                                r_used  <= 5'd0;
                                r_state <= S_BYTE;
                            end
                        endcase
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_BYTE: begin
                    pb = r_item.cipher_byte ^ r_ks[127 - 8*r_used[3:0] -: 8];
                    r_out   <= '{KIND_PLAIN, pb, 1'b0};
                    r_used  <= r_used + 5'd1;
                    r_part[127 - 8*r_fill -: 8] <= r_item.cipher_byte;
                    r_fill  <= r_fill + 4'd1;
                    r_count <= r_count + 1'b1;
                    r_state <= (r_fill == 4'd15) ? S_HASH : S_OUT;
                end
                S_HASH: begin
                    if (gh_done) begin
                        r_wait <= 1'b0;
                        if (r_item.mode == MODE_CHECK) begin
                            r_tacc  <= gh_z;
                            r_state <= S_LEN;
                        end else begin
                            r_acc   <= gh_z;
                            r_part  <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_LEN: begin
                    if (gh_done) begin
                        r_wait  <= 1'b0;
                        r_tacc  <= gh_z;
                        r_state <= S_AES;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_state != S_IDLE || $past(i_in.mode) == 2'd3)
        else $error("item dropped");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid) else $error("result lost");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= 5'd16) else $error("keystream index out of range");
endmodule

FILE: tb/testbench.sv
// ============================================================================
// AES-256-GCM stream decrypt testbench
// Runs directed and random messages through the decryptor and checks every
// result item against a behavioural GCM model with its own state and key.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import agcm_pkg::*;

    localparam int CountBits = CountBitsDefault;
    localparam int TotalItems = 1900;
    localparam int QuietFrom = 1700;
    localparam int WatchLimit = 5000;
    localparam int DrainCycles = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    aes256_gcm_stream_decrypt dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Configuration copy and model state.
    logic [63:0]  cfg_reg [6];
    logic [7:0]   subst [256];
    logic [127:0] round_keys [15];
    logic [127:0] hkey, ks_block, ghash_acc, ghash_part;
    logic [95:0]  nonce;
    logic [31:0]  ctr;
    int           ks_used, part_fill;
    logic [CountBits-1:0] byte_count;

    t_out_item pending_results [$];
    int  errors = 0;
    int  sent = 0;
    bit  quiet = 0;

    function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    // The S-box is built from the field inverse and the affine map.
    function automatic void build_subst();
        logic [7:0] p, r, b;
        for (int x = 0; x < 256; x++) begin
            p = x[7:0];
            r = 8'h01;
            for (int k = 1; k < 8; k++) begin
                p = gmul8(p, p);
                r = gmul8(r, p);
            end
            b = (x == 0) ? 8'h00 : r;
            subst[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                       ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
    endfunction

    function automatic void expand_key(input logic [255:0] key);
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) w[i] = key[255-32*i -: 32];
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = {subst[t[23:16]] ^ rc, subst[t[15:8]], subst[t[7:0]], subst[t[31:24]]};
                rc = gmul8(rc, 8'h02);
            end else if (i % 8 == 4) begin
                t = {subst[t[31:24]], subst[t[23:16]], subst[t[15:8]], subst[t[7:0]]};
            end
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] v;
        v = blk ^ round_keys[0];
        for (int r = 1; r < 15; r++) begin
            for (int k = 0; k < 16; k++) s[k] = subst[v[127-8*k -: 8]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) % 4)];
            if (r < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gmul8(a0 ^ a1, 8'h02);
                    t[4*c+1] = a1 ^ al ^ gmul8(a1 ^ a2, 8'h02);
                    t[4*c+2] = a2 ^ al ^ gmul8(a2 ^ a3, 8'h02);
                    t[4*c+3] = a3 ^ al ^ gmul8(a3 ^ a0, 8'h02);
                end
            end
            for (int k = 0; k < 16; k++) v[127-8*k -: 8] = t[k];
            v ^= round_keys[r];
        end
        return v;
    endfunction

    // Product in GF(2^128) with GCM's reflected bit order.
    function automatic logic [127:0] ghash_mul(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] z;
        z = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) z ^= y;
            y = {1'b0, y[127:1]} ^ (y[0] ? {8'he1, 120'd0} : 128'd0);
        end
        return z;
    endfunction

    function automatic logic [127:0] tag_now();
        logic [127:0] a;
        a = ghash_acc;
        if (part_fill > 0) a = ghash_mul(a ^ ghash_part, hkey);
        a = ghash_mul(a ^ {64'd0, 64'(byte_count) << 3}, hkey);
        return a ^ encrypt_block({nonce, 32'd1});
    endfunction

    // Advances the model by one item; returns 0 where no result follows.
    function automatic bit decrypt_step(input t_in_item it, output t_out_item res);
        res = '0;
        case (it.mode)
            MODE_START: begin
                expand_key({cfg_reg[REG_KEY0], cfg_reg[REG_KEY1],
                            cfg_reg[REG_KEY2], cfg_reg[REG_KEY3]});
                hkey = encrypt_block('0);
                nonce = {cfg_reg[REG_IVUP], cfg_reg[REG_IVLO][31:0]};
                ctr = 32'd2;
                ks_block = '0;
                ks_used = 16;
                ghash_acc = '0;
                ghash_part = '0;
                part_fill = 0;
                byte_count = '0;
                res.result_kind = KIND_START;
            end
            MODE_BYTE: begin
                if (ks_used >= 16) begin
                    ks_block = encrypt_block({nonce, ctr});
                    ctr = ctr + 32'd1;
                    ks_used = 0;
                end
                res.result_kind = KIND_PLAIN;
                res.plain_byte = it.cipher_byte ^ ks_block[127-8*ks_used -: 8];
                ks_used++;
                ghash_part[127-8*part_fill -: 8] = it.cipher_byte;
                part_fill++;
                if (part_fill == 16) begin
                    ghash_acc = ghash_mul(ghash_acc ^ ghash_part, hkey);
                    ghash_part = '0;
                    part_fill = 0;
                end
                byte_count = byte_count + 1'b1;
            end
            MODE_CHECK: begin
                res.result_kind = KIND_TAG;
                res.tag_match = (tag_now() == {it.tag_upper, it.tag_lower});
            end
            default: return 0;
        endcase
        return 1;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_reg[idx] = (idx == REG_IVLO) ? {32'd0, val[31:0]} : val;
    endtask

    // Lowers valid and lets the block drain before registers change.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it, input bit lit, input t_out_item lit_res);
        t_out_item res;
        bit has;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        has = decrypt_step(it, res);
        if (has) pending_results.push_back(lit ? lit_res : res);
        sent++;
        if (sent >= QuietFrom) quiet = 1;
    endtask

    function automatic t_in_item rand_item(input logic [1:0] mode);
        t_in_item it;
        it.mode = mode;
        it.cipher_byte = 8'($urandom);
        it.tag_upper = {$urandom, $urandom};
        it.tag_lower = {$urandom, $urandom};
        return it;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_check(input bit good);
        t_in_item it;
        logic [127:0] tg;
        it = rand_item(MODE_CHECK);
        tg = tag_now();
        if (good) {it.tag_upper, it.tag_lower} = tg;
        else if ($urandom_range(0, 1)) {it.tag_upper, it.tag_lower} = tg ^ (128'd1 << $urandom_range(0, 127));
        send_item(it, 0, '0);
    endtask

    typedef struct {
        logic [1:0] mode;
        logic [7:0] cbyte;
        logic [127:0] tag;
        bit good_tag;
        bit lit;
        t_out_item lit_res;
    } t_row;

    localparam t_out_item StartDone = '{result_kind: KIND_START, plain_byte: 8'h00,
                                        tag_match: 1'b0};

    t_row rows [] = '{
        '{MODE_START, 8'h00, '0, 0, 1, StartDone},
        '{MODE_CHECK, 8'h00, '0, 1, 0, '0},
        '{MODE_CHECK, 8'hff, '0, 0, 0, '0},
        '{MODE_BYTE,  8'h00, '1, 0, 0, '0},
        '{MODE_BYTE,  8'hff, '0, 0, 0, '0},
        '{2'd3,       8'h5a, '1, 0, 0, '0},
        '{MODE_BYTE,  8'h80, '0, 0, 0, '0},
        '{MODE_BYTE,  8'h01, '0, 0, 0, '0},
        '{MODE_CHECK, 8'h00, '0, 1, 0, '0},
        '{MODE_BYTE,  8'h55, '0, 0, 0, '0},
        '{MODE_BYTE,  8'haa, '0, 0, 0, '0},
        '{MODE_CHECK, 8'h00, '1, 0, 0, '0},
        '{MODE_START, 8'hff, '1, 0, 1, StartDone},
        '{MODE_BYTE,  8'h12, '0, 0, 0, '0},
        '{MODE_CHECK, 8'h00, '0, 1, 0, '0}
    };

    initial begin
        t_in_item it;
        int nbytes;
        build_subst();
        for (int i = 0; i < 6; i++) cfg_reg[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the reset key, then with all ones.
        for (int pass = 0; pass < 2; pass++) begin
            foreach (rows[r]) begin
                it = rand_item(rows[r].mode);
                it.cipher_byte = rows[r].cbyte;
                {it.tag_upper, it.tag_lower} = rows[r].tag;
                if (rows[r].good_tag) send_check(1);
                else send_item(it, rows[r].lit, rows[r].lit_res);
                // A run of 17 bytes crosses a keystream and a hash block.
                if (r == 10) for (int k = 0; k < 17; k++) send_item(rand_item(MODE_BYTE), 0, '0);
            end
            wait_idle();
            for (int i = REG_KEY0; i <= REG_IVLO; i++) cfg_write(i[2:0], '1);
        end

        while (sent < TotalItems) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                for (int i = REG_KEY0; i <= REG_IVLO; i++)
                    if ($urandom_range(0, 1)) cfg_write(i[2:0], rand_word());
            end
            send_item(rand_item(MODE_START), 0, '0);
            nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 40);
            for (int k = 0; k < nbytes; k++) begin
                if ($urandom_range(0, 14) == 0) send_item(rand_item(2'd3), 0, '0);
                if ($urandom_range(0, 29) == 0) send_check($urandom_range(0, 1));
                send_item(rand_item(MODE_BYTE), 0, '0);
            end
            // Some messages are left without a check.
            if ($urandom_range(0, 19) != 0) send_check($urandom_range(0, 4) != 0);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Receiver stalls come in bursts until the final stretch.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %p", o_out);
            end else begin
                e = pending_results.pop_front();
                if (o_out.result_kind !== e.result_kind || o_out.plain_byte !== e.plain_byte
                        || o_out.tag_match !== e.tag_match) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", e, o_out);
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
